// ----- hw/rtl/rotation_matrix_to_quaternion_unit_assert.svh -----
// Assertion macros for the rotation matrix to quaternion unit.
// Expects aclk and aresetn in the scope of each use.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RMQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rmq_pkg.sv -----
// Shared types and constants of the rotation matrix to quaternion unit.
// No dependencies.
package rmq_pkg;

    localparam int ElemW     = 16;
    localparam int NumElems  = 9;
    localparam int QuatW     = 16;
    localparam int SumW      = 18;   // trace and radicand before the sign check
    localparam int RadW      = 17;   // positive radicand
    localparam int NumW      = 17;   // numerator magnitude
    localparam int ScaleSh   = 12;   // times 4096
    localparam int SqW       = 30;   // radicand times 4096
    localparam int SqrtSteps = 15;
    localparam int RootW     = 15;
    localparam int DivSteps  = 24;   // quotient bits
    localparam int RemW      = 15;
    localparam int NumLanes  = 3;
    localparam int QDepth    = 4;
    localparam int QPtrW     = 2;
    localparam int QOne      = 16384;

    typedef enum logic [1:0] {
        CASE_TRACE = 2'd0,
        CASE_X     = 2'd1,
        CASE_Y     = 2'd2,
        CASE_Z     = 2'd3
    } case_t;

    typedef struct packed {
        logic            neg;
        logic [NumW-1:0] mag;
    } lane_t;

    typedef struct packed {
        case_t                    sel;
        logic                     fault;
        logic [RadW-1:0]          rad;
        lane_t [NumLanes-1:0]     lane;
    } item_t;

    typedef struct packed {
        logic                neg;
        logic [NumW-1:0]     mag;
        logic [RemW-1:0]     rem;
        logic [DivSteps-1:0] xlo;
        logic [DivSteps-1:0] quo;
    } dlane_t;

    typedef struct packed {
        logic                  valid;
        case_t                 sel;
        logic                  fault;
        logic [SqW-1:0]        n;
        logic [SqW-1:0]        r;
        logic [RootW-1:0]      d;
        dlane_t [NumLanes-1:0] lane;
    } stage_t;

endpackage

// ----- hw/rtl/rmq_front.sv -----
// Front end: accepts a matrix beat, picks the case, forms radicand and numerators.
// Depends on rmq_pkg.
module rmq_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [143:0]          s_tdata,
    output logic                  f_valid,
    input  logic                  f_ready,
    output rmq_pkg::item_t        f_item
);

    localparam int ElemW = rmq_pkg::ElemW;
    localparam int SumW  = rmq_pkg::SumW;
    localparam int NumW  = rmq_pkg::NumW;
    localparam int RadW  = rmq_pkg::RadW;

    logic                  f_valid_reg;
    rmq_pkg::item_t        f_item_reg;
    rmq_pkg::item_t        item_next;
    logic signed [SumW-1:0] e [rmq_pkg::NumElems];
    logic signed [SumW-1:0] tr, rad;

    function automatic rmq_pkg::lane_t mk_lane(input logic signed [SumW-1:0] a,
                                               input logic signed [SumW-1:0] b,
                                               input logic sub);
        rmq_pkg::lane_t         l;
        logic signed [SumW-1:0] v;
        v = sub ? (a - b) : (a + b);
        l.neg = v[SumW-1];
        l.mag = v[SumW-1] ? NumW'(-v) : NumW'(v);
        return l;
    endfunction

    always_comb begin
        for (int i = 0; i < rmq_pkg::NumElems; i++) begin
            e[i] = SumW'($signed(s_tdata[ElemW*i +: ElemW]));
        end
        tr = e[0] + e[4] + e[8];
        item_next = '0;
        priority if (tr > 0) begin
            item_next.sel     = rmq_pkg::CASE_TRACE;
            rad               = SumW'(rmq_pkg::QOne) + tr;
            item_next.lane[0] = mk_lane(e[7], e[5], 1'b1);
            item_next.lane[1] = mk_lane(e[2], e[6], 1'b1);
            item_next.lane[2] = mk_lane(e[3], e[1], 1'b1);
        end else if (e[0] > e[4] && e[0] > e[8]) begin
            item_next.sel     = rmq_pkg::CASE_X;
            rad               = SumW'(rmq_pkg::QOne) + e[0] - e[4] - e[8];
            item_next.lane[0] = mk_lane(e[7], e[5], 1'b1);
            item_next.lane[1] = mk_lane(e[1], e[3], 1'b0);
            item_next.lane[2] = mk_lane(e[2], e[6], 1'b0);
        end else if (e[4] > e[8]) begin
            item_next.sel     = rmq_pkg::CASE_Y;
            rad               = SumW'(rmq_pkg::QOne) + e[4] - e[0] - e[8];
            item_next.lane[0] = mk_lane(e[2], e[6], 1'b1);
            item_next.lane[1] = mk_lane(e[1], e[3], 1'b0);
            item_next.lane[2] = mk_lane(e[5], e[7], 1'b0);
        end else begin
            item_next.sel     = rmq_pkg::CASE_Z;
            rad               = SumW'(rmq_pkg::QOne) + e[8] - e[0] - e[4];
            item_next.lane[0] = mk_lane(e[3], e[1], 1'b1);
            item_next.lane[1] = mk_lane(e[2], e[6], 1'b0);
            item_next.lane[2] = mk_lane(e[5], e[7], 1'b0);
        end
        item_next.fault = rad[SumW-1] || (rad == '0);
        item_next.rad   = item_next.fault ? '0 : rad[RadW-1:0];
    end

    // hold the classified beat until the queue takes it
    assign s_tready = !f_valid_reg || f_ready;
    assign f_valid  = f_valid_reg;
    assign f_item   = f_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (s_tready) begin
            f_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            f_item_reg <= item_next;
        end
    end

endmodule

// ----- hw/rtl/rmq_queue.sv -----
// Short queue between front end and arithmetic back end.
// Depends on rmq_pkg.
module rmq_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  rmq_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output rmq_pkg::item_t out_item
);

    localparam int PtrW = rmq_pkg::QPtrW;

    rmq_pkg::item_t  mem_reg [rmq_pkg::QDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]   count_reg, count_next;
    logic            push, pop;

    assign in_ready  = count_reg != (PtrW+1)'(rmq_pkg::QDepth);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- hw/rtl/rmq_back.sv -----
// Back end: pipelined rounded square root, three pipelined dividers, output register.
// Depends on rmq_pkg.
module rmq_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  rmq_pkg::item_t q_item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata,
    output logic [2:0]     m_tuser
);

    localparam int SqW       = rmq_pkg::SqW;
    localparam int SqrtSteps = rmq_pkg::SqrtSteps;
    localparam int DivSteps  = rmq_pkg::DivSteps;
    localparam int RootW     = rmq_pkg::RootW;
    localparam int RemW      = rmq_pkg::RemW;
    localparam int QuatW     = rmq_pkg::QuatW;
    localparam int ScaleSh   = rmq_pkg::ScaleSh;
    localparam int NumLanes  = rmq_pkg::NumLanes;
    localparam int NStg      = SqrtSteps + DivSteps + 3;

    rmq_pkg::stage_t pipe_reg  [NStg];
    rmq_pkg::stage_t pipe_next [NStg];
    logic            out_valid_reg;
    logic [63:0]     out_data_reg, out_data_next;
    logic [2:0]      out_user_reg;
    logic            en;
    logic [QuatW-1:0] lv [NumLanes];
    logic [QuatW-1:0] dv;

    function automatic rmq_pkg::stage_t stage_step(input int s, input rmq_pkg::stage_t a);
        rmq_pkg::stage_t o;
        logic [SqW-1:0]  bitv;
        logic [SqW-1:0]  x;
        logic [RemW:0]   t;
        o = a;
        if (s <= SqrtSteps) begin
            // one digit of the root per stage
            bitv = SqW'(1) << (2 * (SqrtSteps - s));
            if (a.n >= a.r + bitv) begin
                o.n = a.n - (a.r + bitv);
                o.r = (a.r >> 1) + bitv;
            end else begin
                o.r = a.r >> 1;
            end
        end else if (s == SqrtSteps + 1) begin
            // round to nearest
            o.d = (a.n > a.r) ? RootW'(a.r + SqW'(1)) : RootW'(a.r);
        end else if (s == SqrtSteps + 2) begin
            for (int l = 0; l < NumLanes; l++) begin
                x = SqW'({a.lane[l].mag, {ScaleSh{1'b0}}}) + SqW'(a.d >> 1);
                o.lane[l].rem = RemW'(x[SqW-1:DivSteps]);
                o.lane[l].xlo = x[DivSteps-1:0];
                o.lane[l].quo = '0;
            end
        end else begin
            // one quotient bit per stage
            for (int l = 0; l < NumLanes; l++) begin
                t = {a.lane[l].rem, a.lane[l].xlo[DivSteps-1]};
                if (t >= {1'b0, a.d}) begin
                    o.lane[l].rem = RemW'(t - {1'b0, a.d});
                    o.lane[l].quo = {a.lane[l].quo[DivSteps-2:0], 1'b1};
                end else begin
                    o.lane[l].rem = t[RemW-1:0];
                    o.lane[l].quo = {a.lane[l].quo[DivSteps-2:0], 1'b0};
                end
                o.lane[l].xlo = a.lane[l].xlo << 1;
            end
        end
        return o;
    endfunction

    function automatic logic [QuatW-1:0] sat_q(input logic neg, input logic [DivSteps-1:0] q);
        logic [QuatW-1:0] v;
        if (neg) begin
            v = (q > DivSteps'(32768)) ? 16'h8000 : QuatW'(-q);
        end else begin
            v = (q > DivSteps'(32767)) ? 16'h7fff : QuatW'(q);
        end
        return v;
    endfunction

    // advance the whole pipe unless the output beat is stuck
    assign en      = !out_valid_reg || m_tready;
    assign q_ready = en;

    always_comb begin
        pipe_next[0]       = '0;
        pipe_next[0].valid = q_valid;
        pipe_next[0].sel   = q_item.sel;
        pipe_next[0].fault = q_item.fault;
        pipe_next[0].n     = SqW'({q_item.rad, {ScaleSh{1'b0}}});
        for (int l = 0; l < NumLanes; l++) begin
            pipe_next[0].lane[l].neg = q_item.lane[l].neg;
            pipe_next[0].lane[l].mag = q_item.lane[l].mag;
        end
        for (int s = 1; s < NStg; s++) begin
            pipe_next[s] = stage_step(s, pipe_reg[s-1]);
        end
    end

    always_comb begin
        for (int l = 0; l < NumLanes; l++) begin
            lv[l] = sat_q(pipe_reg[NStg-1].lane[l].neg, pipe_reg[NStg-1].lane[l].quo);
        end
        dv = QuatW'(pipe_reg[NStg-1].d);
        // pack z, y, x, w from the top down
        unique case (pipe_reg[NStg-1].sel)
            rmq_pkg::CASE_TRACE: out_data_next = {lv[2], lv[1], lv[0], dv};
            rmq_pkg::CASE_X:     out_data_next = {lv[2], lv[1], dv, lv[0]};
            rmq_pkg::CASE_Y:     out_data_next = {lv[2], dv, lv[1], lv[0]};
            rmq_pkg::CASE_Z:     out_data_next = {dv, lv[2], lv[1], lv[0]};
            default:             out_data_next = '0;
        endcase
        if (pipe_reg[NStg-1].fault) begin
            out_data_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NStg; s++) begin
                pipe_reg[s].valid <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (en) begin
            pipe_reg      <= pipe_next;
            out_valid_reg <= pipe_reg[NStg-1].valid;
        end
        if (en) begin
            out_data_reg <= out_data_next;
            out_user_reg <= {pipe_reg[NStg-1].fault, pipe_reg[NStg-1].sel};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ----- hw/rtl/rotation_matrix_to_quaternion_unit.sv -----
// Rotation matrix to quaternion unit, top level. Uses rmq_pkg, rmq_front, rmq_queue, rmq_back.
// Pipeline: an accepted beat passes the front register, the queue, the 15-stage root pipe,
//   the 24-stage divider pipe and the output register on its way to m_tdata.
// Throughput: one matrix per cycle while m_tready stays high.
// Reset: aresetn synchronous, active low; empties the queue and all valid bits.
module rotation_matrix_to_quaternion_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // matrix beat
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // m_0_0, m_0_1, m_0_2, m_1_0 .. m_2_2, 16 bits each, low first
    // quaternion beat
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // quat_w, quat_x, quat_y, quat_z, 16 bits each, low first
    output logic [2:0]   m_tuser    // case_taken [1:0], fault [2]
);

    `include "rotation_matrix_to_quaternion_unit_assert.svh"

    logic           f_valid, f_ready;
    rmq_pkg::item_t f_item;
    logic           q_valid, q_ready;
    rmq_pkg::item_t q_item;

    // classify the matrix: case, radicand, three numerators
    rmq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_item   (f_item)
    );

    // decouple the front from stalls on the result side
    rmq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // root, divisions, saturation and output register
    rmq_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // a faulted result carries zero components
    `RMQ_ASSERT_NOW(a_fault_zero, m_tvalid && m_tuser[2], m_tdata == '0, "fault beat has data")
    // the trace-positive case always has a positive radicand
    `RMQ_ASSERT_NOW(a_trace_no_fault, m_tvalid && (m_tuser[1:0] == rmq_pkg::CASE_TRACE), !m_tuser[2], "trace case faulted")
    // the front holds its beat while the queue is full
    `RMQ_ASSERT_NEXT(a_front_hold, f_valid && !f_ready, f_valid && $stable(f_item), "front dropped a beat")

endmodule

// ----- bench/rotation_matrix_to_quaternion_unit_tb.sv -----
// Testbench for rotation_matrix_to_quaternion_unit: drives matrix beats, predicts each quaternion
// with an in-bench four-case converter and compares result beats in order.
// Depends on rmq_pkg and the unit's RTL.
module rotation_matrix_to_quaternion_unit_tb;

    typedef struct {
        logic [15:0]     w, x, y, z;
        rmq_pkg::case_t  sel;
        logic            fault;
    } quat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;   // m_0_0 .. m_2_2, 16 bits each, low first
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;        // quat_w, quat_x, quat_y, quat_z, low first
    logic [2:0]   m_tuser;        // case_taken [1:0], fault [2]

    quat_t quat_due[$];
    int    err_cnt = 0;
    bit    hold_off = 1'b0;

    rotation_matrix_to_quaternion_unit i_dut (.*);

    always #5 aclk = ~aclk;

    // Nearest integer square root, no ties possible.
    function automatic longint root_nearest(longint a);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= a) r = r + 1;
        if (a - r * r > r) r = r + 1;
        return r;
    endfunction

    // num * 4096 / d, rounded half away from zero.
    function automatic longint scaled_quot(longint num, longint d);
        longint mag;
        mag = ((num < 0) ? -num : num) * 4096;
        mag = (mag + d / 2) / d;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic quat_t quat_of_matrix(logic [143:0] mat);
        longint m[3][3];
        longint tr, rad, d, nw, nx, ny, nz, qw, qx, qy, qz;
        quat_t  q;
        for (int i = 0; i < 9; i++) m[i / 3][i % 3] = longint'($signed(mat[16 * i +: 16]));
        nw = 0; nx = 0; ny = 0; nz = 0; qw = 0; qx = 0; qy = 0; qz = 0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            q.sel = rmq_pkg::CASE_TRACE; rad = rmq_pkg::QOne + tr;
            nx = m[2][1] - m[1][2]; ny = m[0][2] - m[2][0]; nz = m[1][0] - m[0][1];
        end else if (m[0][0] > m[1][1] && m[0][0] > m[2][2]) begin
            q.sel = rmq_pkg::CASE_X; rad = rmq_pkg::QOne + m[0][0] - m[1][1] - m[2][2];
            ny = m[0][1] + m[1][0]; nz = m[0][2] + m[2][0]; nw = m[2][1] - m[1][2];
        end else if (m[1][1] > m[2][2]) begin
            q.sel = rmq_pkg::CASE_Y; rad = rmq_pkg::QOne + m[1][1] - m[0][0] - m[2][2];
            nx = m[0][1] + m[1][0]; nz = m[1][2] + m[2][1]; nw = m[0][2] - m[2][0];
        end else begin
            q.sel = rmq_pkg::CASE_Z; rad = rmq_pkg::QOne + m[2][2] - m[0][0] - m[1][1];
            nx = m[0][2] + m[2][0]; ny = m[1][2] + m[2][1]; nw = m[1][0] - m[0][1];
        end
        q.fault = rad <= 0;
        if (!q.fault) begin
            d  = root_nearest(rad * 4096);
            qw = (q.sel == rmq_pkg::CASE_TRACE) ? d : scaled_quot(nw, d);
            qx = (q.sel == rmq_pkg::CASE_X) ? d : scaled_quot(nx, d);
            qy = (q.sel == rmq_pkg::CASE_Y) ? d : scaled_quot(ny, d);
            qz = (q.sel == rmq_pkg::CASE_Z) ? d : scaled_quot(nz, d);
        end
        q.w = clamp16(qw); q.x = clamp16(qx); q.y = clamp16(qy); q.z = clamp16(qz);
        return q;
    endfunction

    // Offer one matrix beat after a random gap; queue its quaternion on acceptance.
    // Leave tvalid high afterwards so the next beat can follow without a gap.
    task automatic send_matrix(logic [143:0] mat);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mat;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        quat_due.push_back(quat_of_matrix(mat));
        @(negedge aclk);
    endtask

    function automatic logic [143:0] pack9(int e[9]);
        logic [143:0] v;
        for (int i = 0; i < 9; i++) v[16 * i +: 16] = e[i][15:0];
        return v;
    endfunction

    // Approximate rotations about a random coordinate axis (|c| + |s| = 16384, small additive noise).
    function automatic logic [143:0] near_rotation();
        int e[9];
        int a, c, s;
        a = $urandom_range(0, 2);
        c = int'($urandom_range(0, 32768)) - 16384;
        s = 16384 - ((c < 0) ? -c : c);
        if ($urandom_range(0, 1)) s = -s;
        for (int i = 0; i < 9; i++) e[i] = 0;
        // plane rotation in the two axes other than a
        e[a * 4] = 16384;
        e[((a + 1) % 3) * 4] = c;
        e[((a + 2) % 3) * 4] = c;
        e[((a + 1) % 3) * 3 + (a + 2) % 3] = -s;
        e[((a + 2) % 3) * 3 + (a + 1) % 3] = s;
        for (int i = 0; i < 9; i++) e[i] = e[i] + int'($urandom_range(0, 64)) - 32;
        if ($urandom_range(0, 3) == 0) begin
            e[a * 4] = -e[a * 4];
            e[((a + 1) % 3) * 4] = -e[((a + 1) % 3) * 4];
        end
        for (int i = 0; i < 9; i++) if (e[i] > 32767) e[i] = 32767;
        return pack9(e);
    endfunction

    task automatic test_directed();
        int e[9];
        logic [143:0] v;
        send_matrix(pack9('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}));
        send_matrix(pack9('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}));   // x dominant
        send_matrix(pack9('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}));   // y dominant
        send_matrix(pack9('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}));   // z dominant
        send_matrix(pack9('{0, 0, 0, 0, 0, 0, 0, 0, 0}));                 // zero trace, z case
        send_matrix(pack9('{5, 0, 0, 0, 5, 0, 0, 0, -10}));                // x and y tie, falls to y
        send_matrix(pack9('{-10, 1, 2, 3, 5, 4, 5, 6, 5}));                // m11 = m22
        // large negative diagonal entries, landing in the z, y and y cases
        send_matrix(pack9('{-20000, 7, 7, 7, -32768, 7, 7, 7, 32767}));
        send_matrix(pack9('{-32768, 7, 7, 7, -20000, 7, 7, 7, -32768}));
        send_matrix(pack9('{-20000, 7, 7, 7, -20000, 7, 7, 7, -32768}));
        // z case with full-scale off-diagonal entries
        send_matrix(pack9('{-16383, 32767, -32768, -32768, -16384, 32767, 32767, -32768, 0}));
        // full-scale entries and large numerators
        send_matrix(pack9('{-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, -16383}));
        send_matrix(pack9('{32767, -32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767}));
        for (int i = 0; i < 9; i++) e[i] = 32767;
        send_matrix(pack9(e));
        for (int i = 0; i < 9; i++) e[i] = -32768;
        send_matrix(pack9(e));
        v = '1;
        send_matrix(v);
    endtask

    task automatic test_random(int count);
        logic [143:0] v;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) != 0) v = near_rotation();
            else for (int i = 0; i < 9; i++) v[16 * i +: 16] = $urandom();
            send_matrix(v);
        end
    endtask

    // Offer back-to-back beats while the receiver holds off, so the pipe fills.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            repeat (120) begin
                s_tvalid <= 1'b1;
                s_tdata  <= near_rotation();
                @(posedge aclk);
                while (!s_tready) @(posedge aclk);
                quat_due.push_back(quat_of_matrix(s_tdata));
                @(negedge aclk);
            end
            begin
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
        join
    endtask

    // Receiver: random stalls, then check every accepted result beat.
    initial begin
        int wait_cyc;
        quat_t exp_q;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else begin
                wait_cyc = $urandom_range(0, 2) == 0 ? $urandom_range(0, 10) : 0;
                if (wait_cyc != 0) begin
                    m_tready <= 1'b0;
                    repeat (wait_cyc) @(negedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk);
                if (m_tvalid) begin
                    if (quat_due.size() == 0) begin
                        $display("%0t: unexpected beat tdata %h tuser %h",
                                 $time, m_tdata, m_tuser);
                        err_cnt++;
                    end else begin
                        exp_q = quat_due.pop_front();
                        if ({exp_q.fault, exp_q.sel, exp_q.z, exp_q.y, exp_q.x, exp_q.w}
                            !== {m_tuser, m_tdata}) begin
                            $display("%0t: mismatch expected w %h x %h y %h z %h case %0d fault %b",
                                     $time, exp_q.w, exp_q.x, exp_q.y, exp_q.z,
                                     exp_q.sel, exp_q.fault);
                            $display("%0t:          actual   w %h x %h y %h z %h case %0d fault %b",
                                     $time, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                                     m_tdata[63:48], m_tuser[1:0], m_tuser[2]);
                            err_cnt++;
                        end
                    end
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random(700);
        test_backpressure();
        test_random(610);
        // drop tvalid once the last beat is taken
        s_tvalid <= 1'b0;
        while (quat_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (err_cnt == 0) $display("rotation_matrix_to_quaternion_unit_tb: clean");
        else $display("rotation_matrix_to_quaternion_unit_tb: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("rotation_matrix_to_quaternion_unit_tb: errors");
        $finish;
    end
endmodule
